>>> design/apdh_pkg.sv
// Package for the atom pair distance histogram.
// Types, codes and fixed constants shared by the controller, datapath and top level.
`default_nettype none

package apdh_pkg;

    localparam int NUM_TYPES = 85;
    localparam int COORD_W   = 20;
    localparam int TYPE_W    = 7;
    localparam int RBIN_W    = 4;
    localparam int CNT_W     = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int D2_W      = 42;

    localparam logic [CFG_W-1:0] BIN_WIDTH_RST = 16'd256;
    localparam logic [CFG_W-1:0] CUTOFF_RST    = 16'd4096;

    localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF    = 1'b1;

    localparam logic ACT_PAIR = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // multiplier operand select
    localparam logic [2:0] MSEL_DX  = 3'd0;
    localparam logic [2:0] MSEL_DY  = 3'd1;
    localparam logic [2:0] MSEL_DZ  = 3'd2;
    localparam logic [2:0] MSEL_CUT = 3'd3;
    localparam logic [2:0] MSEL_ACC = 3'd4;

    // squared distance accumulator
    localparam logic [1:0] D2_HOLD = 2'd0;
    localparam logic [1:0] D2_LOAD = 2'd1;
    localparam logic [1:0] D2_ADD  = 2'd2;

    // memory address select
    localparam logic [1:0] ASEL_FWD  = 2'd0;
    localparam logic [1:0] ASEL_REV  = 2'd1;
    localparam logic [1:0] ASEL_READ = 2'd2;

    // result staging
    localparam logic [1:0] RES_HOLD = 2'd0;
    localparam logic [1:0] RES_ZERO = 2'd1;
    localparam logic [1:0] RES_READ = 2'd2;
    localparam logic [1:0] RES_PAIR = 2'd3;

    // base atom type ranges
    localparam int BASE0_LO = 12;
    localparam int BASE0_HI = 21;
    localparam int BASE1_LO = 34;
    localparam int BASE1_HI = 41;
    localparam int BASE2_LO = 55;
    localparam int BASE2_HI = 61;
    localparam int BASE3_LO = 75;
    localparam int BASE3_HI = 84;

    typedef struct packed {
        logic                      action;
        logic signed [COORD_W-1:0] x_first;
        logic signed [COORD_W-1:0] y_first;
        logic signed [COORD_W-1:0] z_first;
        logic signed [COORD_W-1:0] x_second;
        logic signed [COORD_W-1:0] y_second;
        logic signed [COORD_W-1:0] z_second;
        logic [TYPE_W-1:0]         type_first;
        logic [TYPE_W-1:0]         type_second;
        logic                      adjacent_residues;
        logic [RBIN_W-1:0]         read_bin;
    } t_in_item;

    typedef struct packed {
        logic              pair_counted;
        logic [RBIN_W-1:0] bin_index;
        logic [CNT_W-1:0]  count_value;
    } t_out_item;

    typedef struct packed {
        logic       load;
        logic [2:0] mul_sel;
        logic [1:0] d2_op;
        logic       bin_init;
        logic       bin_step;
        logic [1:0] addr_sel;
        logic       mem_rd;
        logic       mem_wr;
        logic       clr_wr;
        logic [1:0] res_op;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic is_read;
        logic skip;
        logic d2_ge_cut;
        logic prod_le_d2;
        logic bin_last;
        logic same_type;
        logic clr_last;
    } t_dp_stat;

    function automatic logic is_base(input logic [TYPE_W-1:0] t);
        logic r;
        r = (t >= TYPE_W'(BASE0_LO) && t <= TYPE_W'(BASE0_HI)) ||
            (t >= TYPE_W'(BASE1_LO) && t <= TYPE_W'(BASE1_HI)) ||
            (t >= TYPE_W'(BASE2_LO) && t <= TYPE_W'(BASE2_HI)) ||
            (t >= TYPE_W'(BASE3_LO) && t <= TYPE_W'(BASE3_HI));
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/atom_pair_distance_histogram.sv
// Atom pair distance histogram: top level joining controller and datapath.
// Depends on apdh_pkg, apdh_ctrl, apdh_dp (and apdh_ram through apdh_dp).
//
// Input channel (i_in_valid / o_in_stall / i_in_data): one beat is either an
// atom pair to accumulate or a request to read one counter. Output channel
// (o_out_valid / i_out_stall / o_out_data): exactly one result beat per input.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx (0 bin
// width, 1 cutoff), one write per cycle, no read-back.
// One item at a time, a shared squaring multiplier and a single-write, single-read counter
// memory set the pace; a counted pair takes two read-modify-writes of that memory.
// The next beat is accepted the cycle after the result is registered, even
// while that result is still stalled; a stalled result holds its value and
// the block stops one item later until it is taken.
// Reset: synchronous, active low. The counter memory is then cleared one entry
// per cycle, all 85*85*MAX_BINS entries (115600 at the default), with o_in_stall high.
`default_nettype none

module atom_pair_distance_histogram #(
    parameter int MAX_BINS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire apdh_pkg::t_in_item             i_in_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output apdh_pkg::t_out_item                 o_out_data,
    input  wire logic                           i_cfg_we,
    input  wire logic [apdh_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [apdh_pkg::CFG_W-1:0]     i_cfg_data
);

    apdh_pkg::t_dp_cmd  cmd;
    apdh_pkg::t_dp_stat stat;

    apdh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    apdh_dp #(
        .MAX_BINS(MAX_BINS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_data (i_in_data),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .o_out_data(o_out_data)
    );

endmodule

`default_nettype wire

>>> design/apdh_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module apdh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> design/apdh_dp.sv
// Datapath: item register, shared squaring multiplier, bin search, counter memory.
// Depends on apdh_pkg and apdh_ram.
`default_nettype none

module apdh_dp #(
    parameter int MAX_BINS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire apdh_pkg::t_in_item                  i_in_data,
    input  wire logic                                i_cfg_we,
    input  wire logic [apdh_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [apdh_pkg::CFG_W-1:0]          i_cfg_data,
    input  wire apdh_pkg::t_dp_cmd                   i_cmd,
    output apdh_pkg::t_dp_stat                       o_stat,
    output apdh_pkg::t_out_item                      o_out_data
);

    localparam int DEPTH  = apdh_pkg::NUM_TYPES * apdh_pkg::NUM_TYPES * MAX_BINS;
    localparam int AW     = $clog2(DEPTH);
    localparam int BW     = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int ACC_W  = 16 + $clog2(MAX_BINS + 1);
    localparam int MUL_W  = (ACC_W > 21) ? ACC_W : 21;
    localparam int PROD_W = 2 * MUL_W;
    localparam int CW     = apdh_pkg::CNT_W;
    localparam int TW     = apdh_pkg::TYPE_W;

    apdh_pkg::t_in_item  r_item;
    apdh_pkg::t_out_item r_result, r_out;
    logic [apdh_pkg::CFG_W-1:0] r_bin_width, r_cutoff;
    logic [PROD_W-1:0]          r_prod;
    logic [apdh_pkg::D2_W-1:0]  r_d2;
    logic [ACC_W-1:0]           r_acc;
    logic [BW-1:0]              r_bin;
    logic [AW-1:0]              r_clr;

    logic signed [20:0] dx, dy, dz;
    logic [20:0]        adx, ady, adz;
    logic [MUL_W-1:0]   mul_a;
    logic [PROD_W-1:0]  sq;
    logic [apdh_pkg::CFG_W-1:0] w_eff;
    logic               rd_ok;
    logic [AW-1:0]      a_fwd, a_rev, a_read, raddr, waddr;
    logic [CW-1:0]      q, q_inc;
    logic               we;

    function automatic logic [AW-1:0] cell_addr(input logic [TW-1:0] ta,
                                                input logic [TW-1:0] tb,
                                                input logic [6:0]    b);
        logic [31:0] a;
        a = (32'(ta) * 32'(apdh_pkg::NUM_TYPES) + 32'(tb)) * 32'(MAX_BINS) + 32'(b);
        return AW'(a);
    endfunction

    assign dx  = {r_item.x_first[19], r_item.x_first} - {r_item.x_second[19], r_item.x_second};
    assign dy  = {r_item.y_first[19], r_item.y_first} - {r_item.y_second[19], r_item.y_second};
    assign dz  = {r_item.z_first[19], r_item.z_first} - {r_item.z_second[19], r_item.z_second};
    assign adx = dx[20] ? 21'(-dx) : 21'(dx);
    assign ady = dy[20] ? 21'(-dy) : 21'(dy);
    assign adz = dz[20] ? 21'(-dz) : 21'(dz);

    always_comb begin
        case (i_cmd.mul_sel)
            apdh_pkg::MSEL_DX:  mul_a = MUL_W'(adx);
            apdh_pkg::MSEL_DY:  mul_a = MUL_W'(ady);
            apdh_pkg::MSEL_DZ:  mul_a = MUL_W'(adz);
            apdh_pkg::MSEL_CUT: mul_a = MUL_W'(r_cutoff);
            apdh_pkg::MSEL_ACC: mul_a = MUL_W'(r_acc);
            default:            mul_a = '0;
        endcase
    end

    assign sq    = mul_a * mul_a;
    assign w_eff = (r_bin_width == '0) ? apdh_pkg::CFG_W'(1) : r_bin_width;

    assign rd_ok = (r_item.type_first < TW'(apdh_pkg::NUM_TYPES)) &&
                   (r_item.type_second < TW'(apdh_pkg::NUM_TYPES)) &&
                   (32'(r_item.read_bin) < 32'(MAX_BINS));

    assign a_fwd  = cell_addr(r_item.type_first, r_item.type_second, 7'(r_bin));
    assign a_rev  = cell_addr(r_item.type_second, r_item.type_first, 7'(r_bin));
    assign a_read = rd_ok ? cell_addr(r_item.type_first, r_item.type_second,
                                      7'(r_item.read_bin)) : '0;

    always_comb begin
        case (i_cmd.addr_sel)
            apdh_pkg::ASEL_FWD:  raddr = a_fwd;
            apdh_pkg::ASEL_REV:  raddr = a_rev;
            apdh_pkg::ASEL_READ: raddr = a_read;
            default:             raddr = a_fwd;
        endcase
    end

    assign waddr = i_cmd.clr_wr ? r_clr : raddr;
    assign we    = i_cmd.clr_wr | i_cmd.mem_wr;
    assign q_inc = (q == '1) ? q : q + CW'(1);

    apdh_ram #(
        .WIDTH(CW),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(i_cmd.clr_wr ? '0 : q_inc),
        .i_re   (i_cmd.mem_rd),
        .i_raddr(raddr),
        .o_rdata(q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_width <= apdh_pkg::BIN_WIDTH_RST;
            r_cutoff    <= apdh_pkg::CUTOFF_RST;
            r_clr       <= '0;
        end else begin
            if (i_cfg_we && i_cfg_idx == apdh_pkg::CFG_BIN_WIDTH) begin
                r_bin_width <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == apdh_pkg::CFG_CUTOFF) begin
                r_cutoff <= i_cfg_data;
            end
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_data;
        end
        r_prod <= sq;
        case (i_cmd.d2_op)
            apdh_pkg::D2_LOAD: r_d2 <= apdh_pkg::D2_W'(r_prod);
            apdh_pkg::D2_ADD:  r_d2 <= r_d2 + apdh_pkg::D2_W'(r_prod);
            default:           r_d2 <= r_d2;
        endcase
        if (i_cmd.bin_init) begin
            r_acc <= ACC_W'(w_eff);
            r_bin <= '0;
        end else if (i_cmd.bin_step) begin
            r_acc <= r_acc + ACC_W'(w_eff);
            r_bin <= r_bin + BW'(1);
        end
        case (i_cmd.res_op)
            apdh_pkg::RES_ZERO: r_result <= '0;
            apdh_pkg::RES_READ: begin
                r_result.pair_counted <= 1'b0;
                r_result.bin_index    <= r_item.read_bin;
                r_result.count_value  <= rd_ok ? q : '0;
            end
            apdh_pkg::RES_PAIR: begin
                r_result.pair_counted <= 1'b1;
                r_result.bin_index    <= apdh_pkg::RBIN_W'(r_bin);
                r_result.count_value  <= q_inc;
            end
            default: r_result <= r_result;
        endcase
        if (i_cmd.out_load) begin
            r_out <= r_result;
        end
    end

    assign o_stat.is_read    = (r_item.action == apdh_pkg::ACT_READ);
    assign o_stat.skip       = (r_item.type_first >= TW'(apdh_pkg::NUM_TYPES)) ||
                               (r_item.type_second >= TW'(apdh_pkg::NUM_TYPES)) ||
                               (r_item.adjacent_residues &&
                                !apdh_pkg::is_base(r_item.type_first) &&
                                !apdh_pkg::is_base(r_item.type_second));
    assign o_stat.d2_ge_cut  = PROD_W'(r_d2) >= r_prod;
    assign o_stat.prod_le_d2 = r_prod <= PROD_W'(r_d2);
    assign o_stat.bin_last   = (r_bin == BW'(MAX_BINS - 1));
    assign o_stat.same_type  = (r_item.type_first == r_item.type_second);
    assign o_stat.clr_last   = (r_clr == AW'(DEPTH - 1));

    assign o_out_data = r_out;

endmodule

`default_nettype wire

>>> design/apdh_ctrl.sv
// Controller state machine: clearing pass, distance, bin search, counter updates and reads.
// Depends on apdh_pkg.
`default_nettype none

module apdh_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    input  wire apdh_pkg::t_dp_stat i_stat,
    output apdh_pkg::t_dp_cmd       o_cmd
);

    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_DEC   = 5'd2;
    localparam logic [4:0] S_MX    = 5'd3;
    localparam logic [4:0] S_MY    = 5'd4;
    localparam logic [4:0] S_MZ    = 5'd5;
    localparam logic [4:0] S_MC    = 5'd6;
    localparam logic [4:0] S_CC    = 5'd7;
    localparam logic [4:0] S_MB    = 5'd8;
    localparam logic [4:0] S_CB    = 5'd9;
    localparam logic [4:0] S_R1    = 5'd10;
    localparam logic [4:0] S_W1    = 5'd11;
    localparam logic [4:0] S_R2    = 5'd12;
    localparam logic [4:0] S_W2    = 5'd13;
    localparam logic [4:0] S_RR    = 5'd14;
    localparam logic [4:0] S_RW    = 5'd15;
    localparam logic [4:0] S_OUT   = 5'd16;

    logic [4:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.mul_sel  = apdh_pkg::MSEL_DX;
        o_cmd.d2_op    = apdh_pkg::D2_HOLD;
        o_cmd.addr_sel = apdh_pkg::ASEL_FWD;
        o_cmd.res_op   = apdh_pkg::RES_HOLD;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                if (i_stat.is_read) begin
                    n_state = S_RR;
                end else if (i_stat.skip) begin
                    o_cmd.res_op = apdh_pkg::RES_ZERO;
                    n_state      = S_OUT;
                end else begin
                    n_state = S_MX;
                end
            end
            S_MX: begin
                o_cmd.mul_sel = apdh_pkg::MSEL_DX;
                n_state       = S_MY;
            end
            S_MY: begin
                o_cmd.mul_sel = apdh_pkg::MSEL_DY;
                o_cmd.d2_op   = apdh_pkg::D2_LOAD;
                n_state       = S_MZ;
            end
            S_MZ: begin
                o_cmd.mul_sel = apdh_pkg::MSEL_DZ;
                o_cmd.d2_op   = apdh_pkg::D2_ADD;
                n_state       = S_MC;
            end
            S_MC: begin
                o_cmd.mul_sel = apdh_pkg::MSEL_CUT;
                o_cmd.d2_op   = apdh_pkg::D2_ADD;
                n_state       = S_CC;
            end
            S_CC: begin
                if (i_stat.d2_ge_cut) begin
                    o_cmd.res_op = apdh_pkg::RES_ZERO;
                    n_state      = S_OUT;
                end else begin
                    o_cmd.bin_init = 1'b1;
                    n_state        = S_MB;
                end
            end
            S_MB: begin
                o_cmd.mul_sel = apdh_pkg::MSEL_ACC;
                n_state       = S_CB;
            end
            S_CB: begin
                // next bin edge still inside the distance: step up or give up
                if (i_stat.prod_le_d2) begin
                    if (i_stat.bin_last) begin
                        o_cmd.res_op = apdh_pkg::RES_ZERO;
                        n_state      = S_OUT;
                    end else begin
                        o_cmd.bin_step = 1'b1;
                        n_state        = S_MB;
                    end
                end else begin
                    n_state = S_R1;
                end
            end
            S_R1: begin
                o_cmd.addr_sel = apdh_pkg::ASEL_FWD;
                o_cmd.mem_rd   = 1'b1;
                n_state        = S_W1;
            end
            S_W1: begin
                o_cmd.addr_sel = apdh_pkg::ASEL_FWD;
                o_cmd.mem_wr   = 1'b1;
                o_cmd.res_op   = apdh_pkg::RES_PAIR;
                n_state        = S_R2;
            end
            S_R2: begin
                o_cmd.addr_sel = apdh_pkg::ASEL_REV;
                o_cmd.mem_rd   = 1'b1;
                n_state        = S_W2;
            end
            S_W2: begin
                o_cmd.addr_sel = apdh_pkg::ASEL_REV;
                o_cmd.mem_wr   = 1'b1;
                // same counter hit twice: report the second update
                if (i_stat.same_type) begin
                    o_cmd.res_op = apdh_pkg::RES_PAIR;
                end
                n_state = S_OUT;
            end
            S_RR: begin
                o_cmd.addr_sel = apdh_pkg::ASEL_READ;
                o_cmd.mem_rd   = 1'b1;
                n_state        = S_RW;
            end
            S_RW: begin
                o_cmd.res_op = apdh_pkg::RES_READ;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for atom_pair_distance_histogram.
// Depends on apdh_pkg and the design; predicts every result beat and compares it field by field.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HIST_BINS  = 16;
    localparam int WATCHDOG   = 500000;   // covers the clearing pass after reset
    localparam int LONG_HOLD  = 300;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    apdh_pkg::t_in_item in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    apdh_pkg::t_out_item out_data;
    logic cfg_we = 1'b0;
    logic [apdh_pkg::CFG_IDX_W-1:0] cfg_idx = apdh_pkg::CFG_BIN_WIDTH;
    logic [apdh_pkg::CFG_W-1:0] cfg_data = '0;

    always #6 i_clk = ~i_clk;

    atom_pair_distance_histogram dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    // predictor state
    logic [apdh_pkg::CNT_W-1:0] hist_counts [int];
    logic [apdh_pkg::CFG_W-1:0] bin_width_reg = apdh_pkg::BIN_WIDTH_RST;
    logic [apdh_pkg::CFG_W-1:0] cutoff_reg = apdh_pkg::CUTOFF_RST;

    apdh_pkg::t_in_item  pending_beats [$];
    apdh_pkg::t_out_item expected_results [$];
    int  fail_count = 0;
    bit  burst_mode = 0;      // no idling on either side
    bit  hold_request = 0;
    bit  hold_done = 0;
    int  used_ta [$];
    int  used_tb [$];

    function automatic bit base_atom(int t);
        return (t >= 12 && t <= 21) || (t >= 34 && t <= 41) ||
               (t >= 55 && t <= 61) || (t >= 75 && t <= 84);
    endfunction

    function automatic int hist_key(int ta, int tb, int b);
        return (ta * apdh_pkg::NUM_TYPES + tb) * HIST_BINS + b;
    endfunction

    function automatic logic [apdh_pkg::CNT_W-1:0] hist_get(int k);
        return hist_counts.exists(k) ? hist_counts[k] : '0;
    endfunction

    function automatic void hist_bump(int k);
        logic [apdh_pkg::CNT_W-1:0] v;
        v = hist_get(k);
        if (v != '1) v++;
        hist_counts[k] = v;
    endfunction

    function automatic apdh_pkg::t_out_item predict_histogram(apdh_pkg::t_in_item it);
        apdh_pkg::t_out_item r;
        int ta, tb, b;
        longint dx, dy, dz, d2, w, cut;
        r = '0;
        ta = int'(it.type_first);
        tb = int'(it.type_second);
        if (it.action == apdh_pkg::ACT_READ) begin
            r.bin_index = it.read_bin;
            if (ta < apdh_pkg::NUM_TYPES && tb < apdh_pkg::NUM_TYPES)
                r.count_value = hist_get(hist_key(ta, tb, int'(it.read_bin)));
            return r;
        end
        if (ta >= apdh_pkg::NUM_TYPES || tb >= apdh_pkg::NUM_TYPES) return r;
        if (it.adjacent_residues && !base_atom(ta) && !base_atom(tb)) return r;
        dx = longint'($signed(it.x_first)) - longint'($signed(it.x_second));
        dy = longint'($signed(it.y_first)) - longint'($signed(it.y_second));
        dz = longint'($signed(it.z_first)) - longint'($signed(it.z_second));
        d2 = dx * dx + dy * dy + dz * dz;
        cut = longint'(cutoff_reg);
        w = (bin_width_reg == 0) ? 64'sd1 : longint'(bin_width_reg);
        if (d2 >= cut * cut) return r;
        // largest b with (b*w)^2 <= d2
        b = 0;
        while (b < HIST_BINS && ((b + 1) * w) * ((b + 1) * w) <= d2) b++;
        if (b >= HIST_BINS) return r;
        hist_bump(hist_key(ta, tb, b));
        hist_bump(hist_key(tb, ta, b));
        r.pair_counted = 1'b1;
        r.bin_index = b[apdh_pkg::RBIN_W-1:0];
        r.count_value = hist_get(hist_key(ta, tb, b));
        return r;
    endfunction

    // sender
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!(in_valid && in_stall)) begin
            if (in_valid && !in_stall) begin
                expected_results.push_back(predict_histogram(in_data));
            end
            if (send_gap > 0) begin
                send_gap--;
                in_valid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
                in_data <= pending_beats.pop_front();
                in_valid <= 1'b1;
                send_gap = burst_mode ? 0 : int'($urandom_range(0, 4));
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver and checker
    int stall_left = 0;
    always @(posedge i_clk) begin
        apdh_pkg::t_out_item exp_r;
        if (out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                $error("result beat with nothing expected: %h", out_data);
                fail_count++;
            end else begin
                exp_r = expected_results.pop_front();
                if (out_data.pair_counted !== exp_r.pair_counted) begin
                    $error("pair_counted: expected %0d actual %0d",
                           exp_r.pair_counted, out_data.pair_counted);
                    fail_count++;
                end
                if (out_data.bin_index !== exp_r.bin_index) begin
                    $error("bin_index: expected %0d actual %0d",
                           exp_r.bin_index, out_data.bin_index);
                    fail_count++;
                end
                if (out_data.count_value !== exp_r.count_value) begin
                    $error("count_value: expected %0d actual %0d",
                           exp_r.count_value, out_data.count_value);
                    fail_count++;
                end
            end
            stall_left = burst_mode ? 0 : int'($urandom_range(0, 4));
        end
        if (hold_request && !hold_done) begin
            hold_done = 1;
            stall_left = LONG_HOLD;
        end
        if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // watchdog on consecutive cycles without any beat
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // sampled mid-cycle so that the sender's updates of this edge are settled
    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_beats.size() > 0 || in_valid || expected_results.size() > 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [apdh_pkg::CFG_IDX_W-1:0] idx,
                             logic [apdh_pkg::CFG_W-1:0] val);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        if (idx == apdh_pkg::CFG_BIN_WIDTH) bin_width_reg = val;
        else cutoff_reg = val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic int near_offset(int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    function automatic apdh_pkg::t_in_item pair_beat(int ta, int tb, bit adj,
                                                     int dx, int dy, int dz);
        apdh_pkg::t_in_item it;
        it = '0;
        it.action = apdh_pkg::ACT_PAIR;
        it.x_first = 20'($urandom);
        it.y_first = 20'($urandom);
        it.z_first = 20'($urandom);
        it.x_second = 20'(int'(it.x_first) + dx);
        it.y_second = 20'(int'(it.y_first) + dy);
        it.z_second = 20'(int'(it.z_first) + dz);
        it.type_first = 7'(ta);
        it.type_second = 7'(tb);
        it.adjacent_residues = adj;
        it.read_bin = 4'($urandom);
        return it;
    endfunction

    function automatic apdh_pkg::t_in_item read_beat(int ta, int tb, int b);
        apdh_pkg::t_in_item it;
        it = '0;
        it.action = apdh_pkg::ACT_READ;
        it.x_first = 20'($urandom);
        it.z_second = 20'($urandom);
        it.type_first = 7'(ta);
        it.type_second = 7'(tb);
        it.adjacent_residues = 1'($urandom);
        it.read_bin = 4'(b);
        return it;
    endfunction

    function automatic apdh_pkg::t_in_item random_beat(int lim);
        apdh_pkg::t_in_item it;
        int ta, tb, k, sel;
        sel = int'($urandom_range(0, 19));
        if (sel < 5) begin
            if (used_ta.size() > 0 && sel < 4) begin
                k = int'($urandom_range(0, used_ta.size() - 1));
                return read_beat(used_ta[k], used_tb[k], int'($urandom_range(0, 15)));
            end
            return read_beat(int'($urandom_range(0, 127)), int'($urandom_range(0, 127)),
                             int'($urandom_range(0, 15)));
        end
        sel = int'($urandom_range(0, 19));
        ta = int'($urandom_range(0, apdh_pkg::NUM_TYPES - 1));
        tb = int'($urandom_range(0, apdh_pkg::NUM_TYPES - 1));
        if (sel == 0) ta = int'($urandom_range(0, 127));
        else if (sel == 1) tb = int'($urandom_range(0, 127));
        else if (sel < 5) tb = ta;
        else if (sel < 10 && used_ta.size() > 0) begin
            k = int'($urandom_range(0, used_ta.size() - 1));
            ta = used_ta[k];
            tb = used_tb[k];
        end
        if (used_ta.size() < 40 && ta < apdh_pkg::NUM_TYPES && tb < apdh_pkg::NUM_TYPES) begin
            used_ta.push_back(ta);
            used_tb.push_back(tb);
        end
        it = pair_beat(ta, tb, $urandom_range(0, 3) == 0,
                       near_offset(lim), near_offset(lim), near_offset(lim));
        if ($urandom_range(0, 9) == 0) begin
            it.x_second = 20'($urandom);
            it.y_second = 20'($urandom);
            it.z_second = 20'($urandom);
        end
        return it;
    endfunction

    task automatic random_phase(int count, int lim);
        repeat (count) pending_beats.push_back(random_beat(lim));
    endtask

    initial begin
        apdh_pkg::t_in_item it;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, default registers
        pending_beats.push_back(pair_beat(0, 84, 0, 0, 0, 0));
        pending_beats.push_back(pair_beat(84, 0, 0, 100, -200, 50));
        pending_beats.push_back(pair_beat(7, 7, 0, 300, 0, 0));         // same type twice
        pending_beats.push_back(pair_beat(3, 5, 1, 10, 10, 10));        // neighbours, no base
        pending_beats.push_back(pair_beat(3, 12, 1, 10, 10, 10));       // neighbours, one base
        pending_beats.push_back(pair_beat(85, 2, 0, 1, 1, 1));          // type out of range
        pending_beats.push_back(pair_beat(2, 127, 0, 1, 1, 1));
        pending_beats.push_back(pair_beat(21, 34, 0, 4096, 0, 0));      // exactly at cutoff
        pending_beats.push_back(pair_beat(41, 55, 0, 0, 4095, 0));      // last bin
        pending_beats.push_back(pair_beat(61, 75, 1, 0, 0, -255));
        pending_beats.push_back(pair_beat(11, 22, 1, 256, 0, 0));
        it = pair_beat(33, 42, 0, 0, 0, 0);
        it.x_first = 20'sh80000; it.x_second = 20'sh7FFFF;
        it.y_first = 20'sh7FFFF; it.y_second = 20'sh80000;
        pending_beats.push_back(it);                                    // extreme coordinates
        pending_beats.push_back(read_beat(0, 84, 0));
        pending_beats.push_back(read_beat(7, 7, 1));
        pending_beats.push_back(read_beat(41, 55, 15));
        pending_beats.push_back(read_beat(3, 12, 0));
        pending_beats.push_back(read_beat(85, 0, 0));                   // read out of range
        pending_beats.push_back(read_beat(0, 127, 15));
        pending_beats.push_back(read_beat(54, 62, 3));
        wait_idle();

        random_phase(300, 4200);
        hold_request = 1;
        wait_idle();

        write_reg(apdh_pkg::CFG_BIN_WIDTH, 16'd1);
        write_reg(apdh_pkg::CFG_CUTOFF, 16'hFFFF);
        pending_beats.push_back(pair_beat(9, 9, 0, 15, 0, 0));
        pending_beats.push_back(pair_beat(9, 9, 0, 16, 0, 0));          // bin beyond store
        random_phase(250, 20);
        wait_idle();

        write_reg(apdh_pkg::CFG_BIN_WIDTH, 16'hFFFF);
        pending_beats.push_back(pair_beat(1, 2, 0, 65534, 0, 0));
        random_phase(250, 65535);
        wait_idle();

        write_reg(apdh_pkg::CFG_BIN_WIDTH, 16'd0);                      // treated as one
        write_reg(apdh_pkg::CFG_CUTOFF, 16'd16);
        burst_mode = 1;
        random_phase(250, 12);
        wait_idle();
        burst_mode = 0;

        write_reg(apdh_pkg::CFG_CUTOFF, 16'd0);                         // nothing counted
        random_phase(150, 100);
        wait_idle();

        write_reg(apdh_pkg::CFG_BIN_WIDTH, 16'd100);
        write_reg(apdh_pkg::CFG_CUTOFF, 16'd2000);
        random_phase(300, 2100);
        wait_idle();

        write_reg(apdh_pkg::CFG_BIN_WIDTH, apdh_pkg::BIN_WIDTH_RST);
        write_reg(apdh_pkg::CFG_CUTOFF, apdh_pkg::CUTOFF_RST);
        random_phase(330, 4200);
        wait_idle();

        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
